/* hw/rtl/averaged_velocity_damping_force_assert.svh */
// Assertion macros shared by the damping force RTL.
// Expects clk and rst to be in scope where a macro is used.
`ifndef AVERAGED_VELOCITY_DAMPING_FORCE_ASSERT_SVH
`define AVERAGED_VELOCITY_DAMPING_FORCE_ASSERT_SVH

// same-cycle implication
`define AVDF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AVDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/avdf_pkg.sv */
// Package for the averaged velocity damping force block.
// Widths, register indexes and stage control types; no dependencies.
`default_nettype none

package avdf_pkg;

  localparam int VEL_W      = 16;
  localparam int HIST_LOG2  = 6;
  localparam int HIST_DEPTH = 1 << HIST_LOG2;
  localparam int PTR_W      = HIST_LOG2;
  localparam int SUM_W      = VEL_W + HIST_LOG2;
  localparam int GAIN_W     = 16;
  localparam int THR_W      = 15;
  localparam int THR2_W     = 2 * THR_W;
  localparam int SQ_W       = 2 * VEL_W;
  localparam int MAG_W      = SQ_W + 2;
  localparam int PROD_W     = GAIN_W + VEL_W + 1;
  localparam int FORCE_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_THRESHOLD = 2'd1;

  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd0;
  localparam logic [THR_W-1:0]  THR_RST  = 15'd80;

  typedef struct packed {
    logic             ld1;
    logic [PTR_W-1:0] rd_addr;
    logic             ld2;
    logic             push;
    logic [PTR_W-1:0] wr_addr;
    logic             old_ok;
    logic             ld3;
  } lane_ctl_t;

  typedef struct packed {
    logic [SQ_W-1:0]          sq;
    logic signed [PROD_W-1:0] prod;
  } lane_res_t;

  typedef struct packed {
    logic ld4;
    logic on3;
  } merge_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/averaged_velocity_damping_force.sv */
// Averaged velocity viscous damping force, top level.
// Depends on avdf_pkg, avdf_ctrl, avdf_lane, avdf_merge.
//
// Takes one three-axis velocity beat per cycle while in_ready is high and
// returns one force beat per input beat, in order, through the input, mean,
// product and output registers. Per axis lane: history RAM
// read, running sum and 64-sample mean, square and gain product; a merge stage
// compares the squared mean speed with the squared threshold and clamps the
// negated products. Each stage holds when the next one is full, so a waiting
// output only blocks input once all four stages are occupied. With
// damping_gain at zero the history is left alone and a zero force with
// force_on low comes out. Write configuration only while no beat is in flight.
`default_nettype none

module averaged_velocity_damping_force (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_wen,
  input  wire logic [avdf_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  wire logic [avdf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic signed [avdf_pkg::VEL_W-1:0]     vel_x,
  input  wire logic signed [avdf_pkg::VEL_W-1:0]     vel_y,
  input  wire logic signed [avdf_pkg::VEL_W-1:0]     vel_z,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic signed [avdf_pkg::FORCE_W-1:0]        force_x,
  output logic signed [avdf_pkg::FORCE_W-1:0]        force_y,
  output logic signed [avdf_pkg::FORCE_W-1:0]        force_z,
  output logic                                       force_on
);

  logic [avdf_pkg::GAIN_W-1:0] damping_gain;
  logic [avdf_pkg::THR_W-1:0]  speed_threshold;
  avdf_pkg::lane_ctl_t         ctl;
  avdf_pkg::merge_ctl_t        mctl;
  avdf_pkg::lane_res_t         res_x, res_y, res_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      damping_gain    <= avdf_pkg::GAIN_RST;
      speed_threshold <= avdf_pkg::THR_RST;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        avdf_pkg::REG_DAMPING_GAIN: begin
          damping_gain <= cfg_data[avdf_pkg::GAIN_W-1:0];
        end
        avdf_pkg::REG_SPEED_THRESHOLD: begin
          speed_threshold <= cfg_data[avdf_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  avdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .gain_on  (damping_gain != '0),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctl      (ctl),
    .mctl     (mctl),
    .force_on (force_on)
  );

  avdf_lane u_lane_x (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .gain(damping_gain),
    .vel (vel_x),
    .res (res_x)
  );

  avdf_lane u_lane_y (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .gain(damping_gain),
    .vel (vel_y),
    .res (res_y)
  );

  avdf_lane u_lane_z (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .gain(damping_gain),
    .vel (vel_z),
    .res (res_z)
  );

  avdf_merge u_merge (
    .clk    (clk),
    .thresh (speed_threshold),
    .mctl   (mctl),
    .res_x  (res_x),
    .res_y  (res_y),
    .res_z  (res_z),
    .force_x(force_x),
    .force_y(force_y),
    .force_z(force_z)
  );

endmodule

`default_nettype wire

/* hw/rtl/avdf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module avdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/avdf_lane.sv */
// One axis lane: history RAM, running sum, mean, square and gain product.
// Depends on avdf_pkg and avdf_ram.
`default_nettype none

module avdf_lane (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire avdf_pkg::lane_ctl_t                 ctl,
  input  wire logic [avdf_pkg::GAIN_W-1:0]         gain,
  input  wire logic signed [avdf_pkg::VEL_W-1:0]   vel,
  output avdf_pkg::lane_res_t                      res
);

  logic signed [avdf_pkg::VEL_W-1:0]  samp1;
  logic        [avdf_pkg::VEL_W-1:0]  old_raw;
  logic signed [avdf_pkg::VEL_W-1:0]  old_eff;
  logic signed [avdf_pkg::VEL_W-1:0]  mean2;
  logic signed [avdf_pkg::SUM_W-1:0]  sum;
  logic signed [avdf_pkg::SUM_W-1:0]  sum_next;
  logic signed [avdf_pkg::SQ_W-1:0]   sq_c;
  logic signed [avdf_pkg::PROD_W-1:0] prod_c;

  avdf_ram #(
    .WIDTH(avdf_pkg::VEL_W),
    .DEPTH(avdf_pkg::HIST_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (ctl.push),
    .waddr(ctl.wr_addr),
    .wdata(samp1),
    .re   (ctl.ld1),
    .raddr(ctl.rd_addr),
    .rdata(old_raw)
  );

  // never-written entries read as zero
  assign old_eff  = ctl.old_ok ? $signed(old_raw) : '0;
  assign sum_next = sum + avdf_pkg::SUM_W'(samp1) - avdf_pkg::SUM_W'(old_eff);
  assign sq_c     = avdf_pkg::SQ_W'(mean2) * avdf_pkg::SQ_W'(mean2);
  assign prod_c   = avdf_pkg::PROD_W'($signed({1'b0, gain})) * avdf_pkg::PROD_W'(mean2);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctl.push) begin
      sum <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      samp1 <= vel;
    end
    if (ctl.ld2) begin
      mean2 <= avdf_pkg::VEL_W'(sum_next >>> avdf_pkg::HIST_LOG2);
    end
    if (ctl.ld3) begin
      res.sq   <= $unsigned(sq_c);
      res.prod <= prod_c;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/avdf_merge.sv */
// Merge stage: squared magnitude against threshold, force negate and clamp.
// Depends on avdf_pkg.
`default_nettype none

module avdf_merge (
  input  wire logic                                 clk,
  input  wire logic [avdf_pkg::THR_W-1:0]           thresh,
  input  wire avdf_pkg::merge_ctl_t                 mctl,
  input  wire avdf_pkg::lane_res_t                  res_x,
  input  wire avdf_pkg::lane_res_t                  res_y,
  input  wire avdf_pkg::lane_res_t                  res_z,
  output logic signed [avdf_pkg::FORCE_W-1:0]       force_x,
  output logic signed [avdf_pkg::FORCE_W-1:0]       force_y,
  output logic signed [avdf_pkg::FORCE_W-1:0]       force_z
);

  logic [avdf_pkg::THR2_W-1:0] thr2;
  logic [avdf_pkg::MAG_W-1:0]  mag;
  logic                        fire;

  function automatic logic signed [avdf_pkg::FORCE_W-1:0] sat_neg(
    input logic signed [avdf_pkg::PROD_W-1:0] p
  );
    logic signed [avdf_pkg::PROD_W-1:0] n;
    logic                               fits;
    n    = -p;
    fits = (&n[avdf_pkg::PROD_W-1:avdf_pkg::FORCE_W-1]) ||
           !(|n[avdf_pkg::PROD_W-1:avdf_pkg::FORCE_W-1]);
    if (fits) begin
      return n[avdf_pkg::FORCE_W-1:0];
    end else if (n[avdf_pkg::PROD_W-1]) begin
      return {1'b1, {(avdf_pkg::FORCE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(avdf_pkg::FORCE_W-1){1'b1}}};
    end
  endfunction

  // threshold is to be held static by the user while items run; not enforced here
  always_ff @(posedge clk) begin
    thr2 <= avdf_pkg::THR2_W'(thresh) * avdf_pkg::THR2_W'(thresh);
  end

  assign mag  = avdf_pkg::MAG_W'(res_x.sq) + avdf_pkg::MAG_W'(res_y.sq) +
                avdf_pkg::MAG_W'(res_z.sq);
  assign fire = mctl.on3 && (mag > avdf_pkg::MAG_W'(thr2));

  always_ff @(posedge clk) begin
    if (mctl.ld4) begin
      force_x <= fire ? sat_neg(res_x.prod) : '0;
      force_y <= fire ? sat_neg(res_y.prod) : '0;
      force_z <= fire ? sat_neg(res_z.prod) : '0;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/avdf_ctrl.sv */
// Pipeline control: stage valids, ready chain, history pointers, entry valid bits.
// Depends on avdf_pkg and the assertion macro header.
`default_nettype none

`include "averaged_velocity_damping_force_assert.svh"

module avdf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              gain_on,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output avdf_pkg::lane_ctl_t    ctl,
  output avdf_pkg::merge_ctl_t   mctl,
  output logic                   force_on
);

  logic v1, v2, v3;
  logic on1, on2, on3;
  logic ok1;
  logic free1, free2, free3, free4;
  logic ld1, ld2, ld3, ld4, push;
  logic [avdf_pkg::PTR_W-1:0]      rd_ptr;
  logic [avdf_pkg::PTR_W-1:0]      wr_ptr;
  logic [avdf_pkg::HIST_DEPTH-1:0] hv;

  // a stage is free if empty or its beat moves on this cycle
  assign free4 = !out_valid || out_ready;
  assign free3 = !v3 || free4;
  assign free2 = !v2 || free3;
  assign free1 = !v1 || free2;

  assign ld1  = in_valid && free1;
  assign ld2  = v1 && free2;
  assign ld3  = v2 && free3;
  assign ld4  = v3 && free4;
  assign push = ld2 && on1;

  assign in_ready = free1;

  always_comb begin
    ctl.ld1     = ld1;
    ctl.rd_addr = rd_ptr;
    ctl.ld2     = ld2;
    ctl.push    = push;
    ctl.wr_addr = wr_ptr;
    ctl.old_ok  = ok1;
    ctl.ld3     = ld3;
    mctl.ld4    = ld4;
    mctl.on3    = on3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
      rd_ptr    <= '0;
      wr_ptr    <= '0;
      hv        <= '0;
    end else begin
      v1        <= ld1 || (v1 && !ld2);
      v2        <= ld2 || (v2 && !ld3);
      v3        <= ld3 || (v3 && !ld4);
      out_valid <= ld4 || (out_valid && !out_ready);
      if (ld1 && gain_on) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push) begin
        wr_ptr     <= wr_ptr + 1'b1;
        hv[wr_ptr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      on1 <= gain_on;
      ok1 <= hv[rd_ptr];
    end
    if (ld2) begin
      on2 <= on1;
    end
    if (ld3) begin
      on3 <= on2;
    end
    if (ld4) begin
      force_on <= on3;
    end
  end

  `AVDF_ASSERT_NOW(ptr_lockstep, !(v1 && on1), rd_ptr == wr_ptr, "read/write pointers drift")
  `AVDF_ASSERT_NOW(ptr_ahead, v1 && on1, rd_ptr == wr_ptr + 1'b1, "read pointer not one ahead")
  `AVDF_ASSERT_NOW(no_overrun, out_valid && !out_ready, !ld4, "output beat overwritten")
  `AVDF_ASSERT_NOW(stall_full, !in_ready, v1 && v2 && v3 && out_valid, "stall with a bubble")
  `AVDF_ASSERT_NEXT(entry_marked, push, hv[$past(wr_ptr)], "written entry not marked valid")

endmodule

`default_nettype wire

/* bench/averaged_velocity_damping_force_tb.sv */
// Self-checking bench for averaged_velocity_damping_force: random-idling
// valid/ready traffic on both sides, per-beat check against a running-mean model.
// Depends on avdf_pkg and the averaged_velocity_damping_force RTL.

module averaged_velocity_damping_force_tb;
  import avdf_pkg::*;

  localparam int PIPE_LATENCY   = 4;
  localparam int HOLD_OFF       = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NUM_PHASES     = 12;
  localparam int PHASE_ITEMS    = 135;
  localparam int MAX_SHOWN      = 40;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam longint FORCE_MAX = (64'sd1 <<< (FORCE_W - 1)) - 1;
  localparam longint FORCE_MIN = -(64'sd1 <<< (FORCE_W - 1));

  typedef logic signed [VEL_W-1:0] vel_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] x;
    logic signed [FORCE_W-1:0] y;
    logic signed [FORCE_W-1:0] z;
    logic                      on;
  } force_beat_t;

  typedef enum {VM_FULL, VM_DRIFT, VM_SMALL} vel_mode_e;

  class force_scoreboard;
    logic [GAIN_W-1:0]       gain;
    logic [THR_W-1:0]        thr;
    vel_t                    hist [3][HIST_DEPTH];
    logic signed [SUM_W-1:0] sum [3];
    logic [PTR_W-1:0]        wr_ptr;
    force_beat_t             pending_q [$];
    int errors, checked, n_in, n_force, n_dead, n_off, n_cfg;

    function new();
      gain = GAIN_RST;
      thr  = THR_RST;
      for (int a = 0; a < 3; a++) begin
        sum[a] = '0;
        for (int i = 0; i < HIST_DEPTH; i++) hist[a][i] = '0;
      end
      wr_ptr = '0;
      errors = 0; checked = 0; n_in = 0;
      n_force = 0; n_dead = 0; n_off = 0; n_cfg = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      n_cfg++;
      if (idx == REG_DAMPING_GAIN) gain = data[GAIN_W-1:0];
      else if (idx == REG_SPEED_THRESHOLD) thr = data[THR_W-1:0];
    endfunction

    function void note_sample(vel_t vx, vel_t vy, vel_t vz);
      vel_t                      v [3];
      longint                    m [3];
      longint                    mag2, thr2, f;
      logic signed [FORCE_W-1:0] fc [3];
      force_beat_t               e;
      v[0] = vx; v[1] = vy; v[2] = vz;
      e = '0;
      n_in++;
      if (gain == '0) begin
        n_off++;
      end else begin
        mag2 = 0;
        for (int a = 0; a < 3; a++) begin
          sum[a] = sum[a] + v[a] - hist[a][wr_ptr];
          hist[a][wr_ptr] = v[a];
          m[a] = longint'(sum[a] >>> HIST_LOG2);
          mag2 += m[a] * m[a];
          fc[a] = '0;
        end
        wr_ptr++;
        thr2 = longint'(thr) * longint'(thr);
        if (mag2 > thr2) begin
          n_force++;
          for (int a = 0; a < 3; a++) begin
            f = -(longint'(gain) * m[a]);
            if (f > FORCE_MAX) f = FORCE_MAX;
            if (f < FORCE_MIN) f = FORCE_MIN;
            fc[a] = f[FORCE_W-1:0];
          end
        end else begin
          n_dead++;
        end
        e.x = fc[0]; e.y = fc[1]; e.z = fc[2];
        e.on = 1'b1;
      end
      pending_q.push_back(e);
    endfunction

    task report(string what, logic [FORCE_W-1:0] got_v, logic [FORCE_W-1:0] exp_v);
      errors++;
      if (errors <= MAX_SHOWN)
        $display("mismatch at beat %0d: %s got %h expected %h", checked, what, got_v, exp_v);
    endtask

    task check_force(force_beat_t got);
      force_beat_t e;
      checked++;
      if (pending_q.size() == 0) begin
        report("beat with nothing pending", got.x, '0);
        return;
      end
      e = pending_q.pop_front();
      if (got.x !== e.x) report("force_x", got.x, e.x);
      if (got.y !== e.y) report("force_y", got.y, e.y);
      if (got.z !== e.z) report("force_z", got.z, e.z);
      if (got.on !== e.on) report("force_on", FORCE_W'(got.on), FORCE_W'(e.on));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  vel_t vel_x, vel_y, vel_z;
  logic out_valid;
  logic out_ready;
  logic signed [FORCE_W-1:0] force_x, force_y, force_z;
  logic force_on;

  bit burst;
  bit hold_req;
  force_scoreboard sb;

  averaged_velocity_damping_force u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .force_x   (force_x),
    .force_y   (force_y),
    .force_z   (force_z),
    .force_on  (force_on)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_sample(input int vx, input int vy, input int vz);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    cfg_wen <= 1'b0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    vel_x <= vel_t'(vx);
    vel_y <= vel_t'(vy);
    vel_z <= vel_t'(vz);
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_sample(vel_x, vel_y, vel_z);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wen  <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  // stop offering, let every pending force beat come back, then settle
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_wen  <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic take_forces();
    int stall;
    force_beat_t got;
    forever begin
      @(negedge clk);
      stall = burst ? 0 : $urandom_range(0, 3);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_OFF;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.x  = force_x;
      got.y  = force_y;
      got.z  = force_z;
      got.on = force_on;
      sb.check_force(got);
    end
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: %0d cycles without a beat", quiet);
    $display("tb: failure");
    $finish;
  end

  initial begin : main_seq
    int                sample [3];
    int                base [3];
    int                spread, span;
    vel_mode_e         mode;
    logic [GAIN_W-1:0] g;
    logic [THR_W-1:0]  t;
    sb = new();
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_idx = REG_DAMPING_GAIN;
    cfg_data = '0;
    in_valid = 1'b0;
    vel_x = '0; vel_y = '0; vel_z = '0;
    out_ready = 1'b0;
    burst = 1'b0;
    hold_req = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    fork
      take_forces();
    join_none

    // gain off after reset: history must stay untouched
    send_sample(32767, -32768, 0);
    send_sample(-1, 1, -32768);
    drain();
    write_reg(REG_DAMPING_GAIN, 16'hFFFF);
    // threshold still at reset value: mean exactly on it, then just above it
    send_sample(5120, 0, 0);
    send_sample(64, 0, 0);
    send_sample(0, -64, 0);
    drain();
    write_reg(REG_SPEED_THRESHOLD, 16'h8000);
    write_reg(REG_SPARE_2, 16'hFFFF);
    write_reg(REG_SPARE_3, 16'hFFFF);
    repeat (3) send_sample(32767, 32767, 32767);
    repeat (3) send_sample(-32768, -32768, -32768);
    send_sample(0, 0, 0);
    drain();
    write_reg(REG_DAMPING_GAIN, 16'h0001);
    write_reg(REG_SPEED_THRESHOLD, 16'h7FFF);
    send_sample(32767, -32768, 32767);
    send_sample(-32768, 32767, -32768);
    drain();
    write_reg(REG_DAMPING_GAIN, 16'h0000);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    drain();
    write_reg(REG_DAMPING_GAIN, 16'h0100);
    write_reg(REG_SPEED_THRESHOLD, 16'h0000);
    send_sample(-1, -1, -1);
    send_sample(0, 0, 0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin g = '1; t = '0; end
        1: begin g = 16'd1; t = '1; end
        2: begin g = 16'h0100; t = THR_RST; end
        default: begin
          case ($urandom_range(0, 9))
            0:       g = '0;
            1, 2:    g = '1;
            default: g = GAIN_W'($urandom_range(1, 65535));
          endcase
          case ($urandom_range(0, 5))
            0:       t = '0;
            1:       t = '1;
            2:       t = THR_RST;
            default: t = THR_W'($urandom_range(0, 3000));
          endcase
        end
      endcase
      write_reg(REG_DAMPING_GAIN, g);
      write_reg(REG_SPEED_THRESHOLD, {1'($urandom_range(0, 1)), t});
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                  CFG_DATA_W'($urandom));

      case ($urandom_range(0, 3))
        0:       mode = VM_FULL;
        1:       mode = VM_SMALL;
        default: mode = VM_DRIFT;
      endcase
      for (int a = 0; a < 3; a++) base[a] = int'($urandom_range(0, 65535)) - 32768;
      spread = $urandom_range(0, 1023);
      span = int'(t) * 2 + 16;
      if (span > 32767) span = 32767;
      burst = ($urandom_range(0, 3) == 0);

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ((ph == 2 || ph == 7) && k == 20) hold_req = 1'b1;
        for (int a = 0; a < 3; a++) begin
          case (mode)
            VM_FULL:  sample[a] = int'($urandom_range(0, 65535)) - 32768;
            VM_DRIFT: sample[a] = ($urandom_range(0, 15) == 0)
                                  ? int'($urandom_range(0, 65535)) - 32768
                                  : base[a] + int'($urandom_range(0, 2 * spread)) - spread;
            default:  sample[a] = int'($urandom_range(0, 2 * span)) - span;
          endcase
        end
        send_sample(sample[0], sample[1], sample[2]);
      end
    end

    drain();
    burst = 1'b0;
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    $display("run: %0d velocity samples, %0d force beats checked, %0d register writes",
             sb.n_in, sb.checked, sb.n_cfg);
    $display("run: %0d beats with force, %0d in deadband, %0d with gain off, %0d mismatches",
             sb.n_force, sb.n_dead, sb.n_off, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/avdf_pkg.sv
hw/rtl/avdf_ram.sv
hw/rtl/avdf_lane.sv
hw/rtl/avdf_merge.sv
hw/rtl/avdf_ctrl.sv
hw/rtl/averaged_velocity_damping_force.sv
bench/averaged_velocity_damping_force_tb.sv
